FILE: rtl/mm3h_pkg.sv
`timescale 1ns / 1ps
// Package for the MurmurHash3 x86_32 byte stream hash unit.
// Holds the scheme constants and the controller/datapath interface types.
package mm3h_pkg;

  localparam logic [31:0] MixC1     = 32'hCC9E2D51;
  localparam logic [31:0] MixC2     = 32'h1B873593;
  localparam logic [31:0] MixN      = 32'hE6546B64;
  localparam logic [31:0] FinM1     = 32'h85EBCA6B;
  localparam logic [31:0] FinM2     = 32'hC2B2AE35;
  localparam logic [31:0] SeedReset = 32'd199933;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCR1,
    ST_SCR2,
    ST_BLOCK,
    ST_TAIL,
    ST_FXOR,
    ST_FM1,
    ST_FM2,
    ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SCR1,
    OP_SCR2,
    OP_BLOCK,
    OP_TAIL,
    OP_FXOR,
    OP_FM1,
    OP_FM2,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_ctrl_t;

  typedef struct packed {
    logic need_block;
    logic finish_now;
    logic has_tail;
    logic tail_mode;
    logic fin_pend;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: rtl/mm3h_datapath.sv
`timescale 1ns / 1ps
// Datapath of the hash unit: message state, seed register, one shared
// 32x32 multiplier with operand selection, and the output register.
// Depends on mm3h_pkg.
module mm3h_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_data_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  logic               empty_message_i,
  input  logic               out_ready_i,
  input  mm3h_pkg::dp_ctrl_t ctrl_i,
  output mm3h_pkg::dp_stat_t stat_o,
  output logic               out_valid_o,
  output logic [31:0]        hash_value_o
);

  logic [31:0] seed_q;
  logic [31:0] hash_q, hash_d;
  logic [23:0] pw_q, pw_d;
  logic [1:0]  pos_q, pos_d;
  logic [31:0] len_q, len_d;
  logic        in_msg_q, in_msg_d;
  logic        fin_pend_q, fin_pend_d;
  logic        tail_q, tail_d;
  logic [31:0] acc_q, acc_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_q, out_d;

  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] mix_t, mix_r, fx_t;

  assign prod = mul_a * mul_b;

  assign mix_t = hash_q ^ acc_q;
  assign mix_r = {mix_t[18:0], mix_t[31:19]};
  assign fx_t  = hash_q ^ acc_q ^ len_q;

  always_comb begin
    mul_a = acc_q;
    mul_b = mm3h_pkg::MixC1;
    unique case (ctrl_i.op)
      mm3h_pkg::OP_SCR2: begin
        mul_a = {acc_q[16:0], acc_q[31:17]};
        mul_b = mm3h_pkg::MixC2;
      end
      mm3h_pkg::OP_FM1: begin
        mul_b = mm3h_pkg::FinM1;
      end
      mm3h_pkg::OP_FM2: begin
        mul_a = acc_q ^ {13'd0, acc_q[31:13]};
        mul_b = mm3h_pkg::FinM2;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    hash_d      = hash_q;
    pw_d        = pw_q;
    pos_d       = pos_q;
    len_d       = len_q;
    in_msg_d    = in_msg_q;
    fin_pend_d  = fin_pend_q;
    tail_d      = tail_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    unique case (ctrl_i.op)
      mm3h_pkg::OP_ACCEPT: begin
        tail_d = 1'b0;
        if (!in_msg_q) begin
          hash_d = seed_q;
        end
        if (empty_message_i) begin
          fin_pend_d = 1'b1;
        end else begin
          in_msg_d   = 1'b1;
          fin_pend_d = last_byte_i;
          len_d      = len_q + 32'd1;
          if (pos_q == 2'd3) begin
            acc_d = {data_byte_i, pw_q};
            pw_d  = '0;
            pos_d = '0;
          end else begin
            case (pos_q)
              2'd0:    pw_d = {pw_q[23:8], data_byte_i};
              2'd1:    pw_d = {pw_q[23:16], data_byte_i, pw_q[7:0]};
              default: pw_d = {data_byte_i, pw_q[15:0]};
            endcase
            pos_d = pos_q + 2'd1;
          end
        end
      end
      mm3h_pkg::OP_SCR1:  acc_d = prod;
      mm3h_pkg::OP_SCR2:  acc_d = prod;
      mm3h_pkg::OP_BLOCK: hash_d = mix_r + {mix_r[29:0], 2'b00} + mm3h_pkg::MixN;
      mm3h_pkg::OP_TAIL: begin
        acc_d  = {8'd0, pw_q};
        tail_d = 1'b1;
      end
      mm3h_pkg::OP_FXOR:  acc_d = fx_t ^ {16'd0, fx_t[31:16]};
      mm3h_pkg::OP_FM1:   acc_d = prod;
      mm3h_pkg::OP_FM2:   acc_d = prod;
      mm3h_pkg::OP_FIN: begin
        out_d       = acc_q ^ {16'd0, acc_q[31:16]};
        out_valid_d = 1'b1;
        pw_d        = '0;
        pos_d       = '0;
        len_d       = '0;
        in_msg_d    = 1'b0;
        fin_pend_d  = 1'b0;
        tail_d      = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= mm3h_pkg::SeedReset;
      hash_q      <= mm3h_pkg::SeedReset;
      pw_q        <= '0;
      pos_q       <= '0;
      len_q       <= '0;
      in_msg_q    <= 1'b0;
      fin_pend_q  <= 1'b0;
      tail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_data_i;
      end
      hash_q      <= hash_d;
      pw_q        <= pw_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      in_msg_q    <= in_msg_d;
      fin_pend_q  <= fin_pend_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    out_q <= out_d;
  end

  assign stat_o.need_block = ~empty_message_i & (pos_q == 2'd3);
  assign stat_o.finish_now = empty_message_i | last_byte_i;
  assign stat_o.has_tail   = (pos_q != 2'd0);
  assign stat_o.tail_mode  = tail_q;
  assign stat_o.fin_pend   = fin_pend_q;
  assign stat_o.out_busy   = out_valid_q & ~out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_q;

  a_pos_tracks_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q[1:0] == pos_q)
    else $error("byte position out of step with length");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_msg_q |-> (len_q == 32'd0) && (pw_q == 24'd0))
    else $error("message state not cleared outside a message");

  a_fin_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == mm3h_pkg::OP_FIN) |-> !(out_valid_q && !out_ready_i))
    else $error("result written over a pending beat");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl_i.op == mm3h_pkg::OP_FIN))
    else $error("result raised without finalize step");

endmodule

FILE: rtl/mm3h_ctrl.sv
`timescale 1ns / 1ps
// Controller of the hash unit: sequences block mixing, tail mixing and
// finalization on the shared multiplier. Depends on mm3h_pkg.
module mm3h_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mm3h_pkg::dp_stat_t stat_i,
  output mm3h_pkg::dp_ctrl_t ctrl_o
);

  mm3h_pkg::state_e state_q, state_d;
  logic             accept;

  assign accept = in_valid_i & (state_q == mm3h_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mm3h_pkg::ST_IDLE: begin
        if (accept) begin
          if (stat_i.need_block) begin
            state_d = mm3h_pkg::ST_SCR1;
          end else if (stat_i.finish_now) begin
            state_d = mm3h_pkg::ST_TAIL;
          end
        end
      end
      mm3h_pkg::ST_SCR1:  state_d = mm3h_pkg::ST_SCR2;
      mm3h_pkg::ST_SCR2:  state_d = stat_i.tail_mode ? mm3h_pkg::ST_FXOR : mm3h_pkg::ST_BLOCK;
      mm3h_pkg::ST_BLOCK: state_d = stat_i.fin_pend ? mm3h_pkg::ST_TAIL : mm3h_pkg::ST_IDLE;
      mm3h_pkg::ST_TAIL:  state_d = stat_i.has_tail ? mm3h_pkg::ST_SCR1 : mm3h_pkg::ST_FXOR;
      mm3h_pkg::ST_FXOR:  state_d = mm3h_pkg::ST_FM1;
      mm3h_pkg::ST_FM1:   state_d = mm3h_pkg::ST_FM2;
      mm3h_pkg::ST_FM2:   state_d = mm3h_pkg::ST_FIN;
      mm3h_pkg::ST_FIN: begin
        if (!stat_i.out_busy) begin
          state_d = mm3h_pkg::ST_IDLE;
        end
      end
      default: state_d = mm3h_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.op  = mm3h_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      mm3h_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          ctrl_o.op = mm3h_pkg::OP_ACCEPT;
        end
      end
      mm3h_pkg::ST_SCR1:  ctrl_o.op = mm3h_pkg::OP_SCR1;
      mm3h_pkg::ST_SCR2:  ctrl_o.op = mm3h_pkg::OP_SCR2;
      mm3h_pkg::ST_BLOCK: ctrl_o.op = mm3h_pkg::OP_BLOCK;
      mm3h_pkg::ST_TAIL:  ctrl_o.op = mm3h_pkg::OP_TAIL;
      mm3h_pkg::ST_FXOR:  ctrl_o.op = mm3h_pkg::OP_FXOR;
      mm3h_pkg::ST_FM1:   ctrl_o.op = mm3h_pkg::OP_FM1;
      mm3h_pkg::ST_FM2:   ctrl_o.op = mm3h_pkg::OP_FM2;
      mm3h_pkg::ST_FIN: begin
        if (!stat_i.out_busy) begin
          ctrl_o.op = mm3h_pkg::OP_FIN;
        end
      end
      default: ctrl_o.op = mm3h_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mm3h_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_block_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mm3h_pkg::ST_SCR2) && !stat_i.tail_mode |=> state_q == mm3h_pkg::ST_BLOCK)
    else $error("block scramble not followed by hash update");

  a_fm_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mm3h_pkg::ST_FM2) |-> $past(state_q == mm3h_pkg::ST_FM1))
    else $error("finalizer multiply out of order");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mm3h_pkg::ST_FIN) && stat_i.out_busy |=> state_q == mm3h_pkg::ST_FIN)
    else $error("finalize step left while output busy");

endmodule

FILE: rtl/murmur3_32_byte_stream_hash_unit.sv
`timescale 1ns / 1ps
// MurmurHash3 x86_32 over a byte stream, one byte per input beat.
// Top level: joins mm3h_ctrl and mm3h_datapath; depends on mm3h_pkg.
//
// Input channel (in_valid_i/in_ready_o): data_byte_i, last_byte_i and
// empty_message_i. A beat with empty_message_i set carries no byte and ends
// the current message (or hashes the zero-length message when idle).
// Output channel (out_valid_o/out_ready_i): one hash_value_o beat per message.
// cfg_we_i/cfg_data_i load the seed; it applies from the next message start.
//
// A byte that does not complete a 4-byte block leaves the unit idle and
// ready for the next byte; one that completes a block occupies it for two
// scramble multiplies on the shared 32x32 multiplier and the hash update.
// After the final beat: block mixing if that byte completes a block, tail
// step, tail scramble for 1 to 3 tail bytes, finalizer XOR, FM1, FM2 and
// finalize step. in_ready_o is low while the sequence runs.
// Reset: seed returns to 199933, message state cleared, no result pending.
// A stalled receiver holds the result in the output register; the unit keeps
// accepting bytes and only waits at the finalize step if a second result is
// ready before the first is taken.
module murmur3_32_byte_stream_hash_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        empty_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] hash_value_o
);

  mm3h_pkg::dp_ctrl_t ctrl;
  mm3h_pkg::dp_stat_t stat;

  mm3h_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  mm3h_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .empty_message_i (empty_message_i),
    .out_ready_i     (out_ready_i),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .hash_value_o    (hash_value_o)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for murmur3_32_byte_stream_hash_unit: a scoreboard class
// predicts the MurmurHash3 x86_32 result of each byte message and checks it.
// Depends on mm3h_pkg (scheme constants) and the unit's top level.

class hash_scoreboard;
  logic [31:0] seed;
  logic [31:0] run_hash;
  logic [31:0] msg_len;
  logic [23:0] tail_bytes;
  logic [1:0]  tail_count;
  bit          active;
  logic [31:0] hash_queue[$];
  int unsigned mismatches;
  int unsigned hashes_checked;
  int unsigned beats_noted;

  function new();
    seed = mm3h_pkg::SeedReset;
    mismatches = 0;
    hashes_checked = 0;
    beats_noted = 0;
    clear_message();
  endfunction

  function void clear_message();
    run_hash   = seed;
    msg_len    = '0;
    tail_bytes = '0;
    tail_count = '0;
    active     = 1'b0;
  endfunction

  function logic [31:0] scramble(logic [31:0] k);
    k = k * mm3h_pkg::MixC1;
    k = {k[16:0], k[31:17]};
    k = k * mm3h_pkg::MixC2;
    return k;
  endfunction

  function logic [31:0] final_hash();
    logic [31:0] h;
    h = active ? run_hash : seed;
    if (tail_count != 2'd0) begin
      h ^= scramble({8'h00, tail_bytes});
    end
    h ^= msg_len;
    h ^= h >> 16;
    h = h * mm3h_pkg::FinM1;
    h ^= h >> 13;
    h = h * mm3h_pkg::FinM2;
    h ^= h >> 16;
    return h;
  endfunction

  // Called for every accepted input beat.
  function void note_input_beat(logic [7:0] b, logic last, logic empty);
    logic [31:0] h;
    beats_noted++;
    if (!empty) begin
      if (!active) begin
        clear_message();
        active = 1'b1;
      end
      if (tail_count == 2'd3) begin
        h = run_hash ^ scramble({b, tail_bytes});
        h = {h[18:0], h[31:19]};
        run_hash = h * 32'd5 + mm3h_pkg::MixN;
        tail_bytes = '0;
        tail_count = '0;
      end else begin
        tail_bytes[8*tail_count +: 8] = b;
        tail_count++;
      end
      msg_len++;
      if (!last) begin
        return;
      end
    end
    hash_queue.push_back(final_hash());
    clear_message();
  endfunction

  // Called for every accepted output beat.
  function void check_hash_beat(logic [31:0] actual);
    logic [31:0] want;
    if (hash_queue.size() == 0) begin
      $error("hash_value: unexpected beat, expected none, actual %08h", actual);
      mismatches++;
      return;
    end
    want = hash_queue.pop_front();
    hashes_checked++;
    if (actual !== want) begin
      $error("hash_value mismatch: expected %08h, actual %08h", want, actual);
      mismatches++;
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseBeats  = 480;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        empty_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] hash_value_o;

  hash_scoreboard sb = new();

  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 64;
  int unsigned hold_left = 0;
  logic        hold_request = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned beats_sent = 0;
  int unsigned seeds_used = 1;

  murmur3_32_byte_stream_hash_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .empty_message_i (empty_message_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hash_value_o    (hash_value_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left = HoldCycles;
      hold_request <= 1'b0;
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_input_beat(data_byte_i, last_byte_i, empty_message_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_hash_beat(hash_value_o);
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last, input logic empty);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    last_byte_i     <= last;
    empty_message_i <= empty;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.hash_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [31:0] value);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.seed = value;
    seeds_used++;
  endtask

  task automatic send_random_message();
    int unsigned n;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) begin
      send_beat(8'($urandom), 1'($urandom), 1'b1);
      return;
    end
    n = (pick < 85) ? $urandom_range(1, 9) : $urandom_range(10, 40);
    for (int unsigned i = 1; i <= n; i++) begin
      pick = $urandom_range(99);
      if (i == n && pick < 6) begin
        send_beat(8'($urandom), 1'($urandom), 1'b1);
      end else if (i < n && pick < 3) begin
        send_beat(8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        send_beat(8'($urandom), i == n, 1'b0);
      end
    end
  endtask

  initial begin
    int unsigned goal;
    bit hold_done;
    hold_done = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset seed, zero-length message, tails of 0, 1 and 3 bytes
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h01, 1'b0, 1'b0);
    send_beat(8'h80, 1'b0, 1'b0);
    send_beat(8'h7F, 1'b0, 1'b0);
    send_beat(8'hFE, 1'b1, 1'b0);
    // both flags set: empty wins
    send_beat(8'hA5, 1'b1, 1'b1);
    // empty flag ends a message in progress
    send_beat(8'h5A, 1'b0, 1'b0);
    send_beat(8'hC3, 1'b0, 1'b0);
    send_beat(8'h3C, 1'b0, 1'b1);
    // seed change mid-message applies only from the next message
    send_beat(8'h11, 1'b0, 1'b0);
    send_beat(8'h22, 1'b0, 1'b0);
    write_seed(32'h0000_0000);
    send_beat(8'h33, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    write_seed(32'hFFFF_FFFF);
    send_beat(8'hFF, 1'b0, 1'b1);
    for (int i = 0; i < 5; i++) begin
      send_beat(8'hFF, i == 4, 1'b0);
    end

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          write_seed($urandom);
          send_idle_pct = 37;
          recv_idle_pct <= 64;
        end
        1: begin
          write_seed($urandom);
          send_idle_pct = 64;
          recv_idle_pct <= 37;
        end
        default: begin
          write_seed(32'h0000_0000);
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      goal = beats_sent + PhaseBeats;
      while (beats_sent < goal) begin
        if (p == 2 && !hold_done && beats_sent + 400 > goal) begin
          hold_request <= 1'b1;
          hold_done = 1'b1;
        end
        send_random_message();
      end
    end

    wait_drained();
    $display("Run covered %0d input beats, %0d checked hashes, %0d seed settings",
             sb.beats_noted, sb.hashes_checked, seeds_used);
    $display("including empty, early-ended and mid-message-seed cases under stalls");
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
